>>> sv/tmde_pkg.sv
// Package for the triangle map distortion energy block.
// Holds the energy mode codes and the fixed-point constants shared by the design.
// No dependencies.
package tmde_pkg;

  // Energy mode register codes.
  localparam logic [1:0] MODE_DIRICHLET = 2'd0;
  localparam logic [1:0] MODE_SYMMETRIC = 2'd1;
  localparam logic [1:0] MODE_MIPS      = 2'd2;
  localparam logic [1:0] MODE_NONE      = 2'd3;

  // Energy values carry two extra bits above the Q16.16 range; the top bit is a saturation mark.
  typedef logic [33:0] energy_t;
  localparam energy_t ENERGY_BIG = 34'h2_0000_0000;

  // Map entries are Q.16 and clamp at the largest magnitude that fits in this many bits.
  localparam int J_QBITS = 30;

  // Colour level: (diff * 255 + 10.0) / 20.0 in Q16.16. The division by 20.0 is a
  // shift by 17 and a multiply by a reciprocal of ten, exact below the clamp point.
  localparam logic [12:0] COLOUR_RECIP = 13'd6554;
  localparam logic [23:0] COLOUR_CLAMP = 24'd2560;
  localparam logic [40:0] COLOUR_HALF  = 41'd655360;
  localparam logic [31:0] BASE_LOW     = 32'h0002_0000;
  localparam logic [31:0] BASE_HIGH    = 32'h0004_0000;

endpackage

>>> sv/triangle_map_distortion_energy_top.sv
// Triangle map distortion energies: singular values, three energies and a colour level.
// One item is taken per cycle while the output is not stalled.
// The dividers by variable values and the square roots are fully pipelined, one bit per
// stage; the colour level uses a shift and a reciprocal multiply.
// A stall at the output freezes the whole pipeline. Synchronous reset clears valid
// bits and sets energy_mode to Dirichlet. Depends on tmde_pkg, tmde_div, tmde_isqrt.
module triangle_map_distortion_energy_top #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                energy_mode_we,
  input  logic [1:0]                          energy_mode_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // rest_x0, rest_y0, rest_x1, rest_y1, rest_x2, rest_y2,
  // def_x0, def_y0, def_x1, def_y1, def_x2, def_y2 (lowest first)
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // sigma_major, sigma_minor, dirichlet_energy, symmetric_energy,
  // conformal_energy, colour_level (lowest first)
  output logic [151:0]                        m_tdata,
  // flipped, degenerate (lowest first)
  output logic [1:0]                          m_tuser
);
  import tmde_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int DFW = CW + 1;
  localparam int PW  = 2 * DFW + 1;
  localparam int XW1 = PW + 17;

  logic       adv;
  logic [1:0] energy_mode;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_mode <= MODE_DIRICHLET;
    end else if (energy_mode_we) begin
      energy_mode <= energy_mode_wdata;
    end
  end

  // Stage A: edge vectors.
  logic signed [CW-1:0]  crd [12];
  logic                  va;
  logic signed [DFW-1:0] p00, p10, p01, p11, q00, q10, q01, q11;

  for (genvar i = 0; i < 12; i++) begin : g_crd
    assign crd[i] = s_tdata[i*CW +: CW];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p00 <= DFW'(crd[2]) - DFW'(crd[0]);
      p10 <= DFW'(crd[3]) - DFW'(crd[1]);
      p01 <= DFW'(crd[4]) - DFW'(crd[0]);
      p11 <= DFW'(crd[5]) - DFW'(crd[1]);
      q00 <= DFW'(crd[8]) - DFW'(crd[6]);
      q10 <= DFW'(crd[9]) - DFW'(crd[7]);
      q01 <= DFW'(crd[10]) - DFW'(crd[6]);
      q11 <= DFW'(crd[11]) - DFW'(crd[7]);
    end
  end

  // Stage B: determinants and the adjugate products.
  logic                 vb;
  logic signed [PW-1:0] det0, detq, na, nb, nc, nd;

  always_ff @(posedge clk) begin
    if (adv) begin
      det0 <= PW'(p00) * PW'(p11) - PW'(p01) * PW'(p10);
      detq <= PW'(q00) * PW'(q11) - PW'(q01) * PW'(q10);
      na   <= PW'(q00) * PW'(p11) - PW'(q01) * PW'(p10);
      nb   <= PW'(q01) * PW'(p00) - PW'(q00) * PW'(p01);
      nc   <= PW'(q10) * PW'(p11) - PW'(q11) * PW'(p10);
      nd   <= PW'(q11) * PW'(p00) - PW'(q10) * PW'(p01);
    end
  end

  // Stage C: magnitudes, rounded dividends, signs and flags.
  logic           vc;
  logic [PW-1:0]  mdet, mna, mnb, mnc, mnd;
  logic [XW1-1:0] xa, xb, xc_j, xd;
  logic [PW-1:0]  dj;
  logic           sa, sb, sc, sd, c_det0z, c_detqz, c_flip;

  assign mdet = det0[PW-1] ? (~det0 + 1'b1) : det0;
  assign mna  = na[PW-1] ? (~na + 1'b1) : na;
  assign mnb  = nb[PW-1] ? (~nb + 1'b1) : nb;
  assign mnc  = nc[PW-1] ? (~nc + 1'b1) : nc;
  assign mnd  = nd[PW-1] ? (~nd + 1'b1) : nd;

  always_ff @(posedge clk) begin
    if (adv) begin
      xa      <= {1'b0, mna, 16'd0} + XW1'(mdet >> 1);
      xb      <= {1'b0, mnb, 16'd0} + XW1'(mdet >> 1);
      xc_j    <= {1'b0, mnc, 16'd0} + XW1'(mdet >> 1);
      xd      <= {1'b0, mnd, 16'd0} + XW1'(mdet >> 1);
      dj      <= mdet;
      sa      <= na[PW-1] ^ det0[PW-1];
      sb      <= nb[PW-1] ^ det0[PW-1];
      sc      <= nc[PW-1] ^ det0[PW-1];
      sd      <= nd[PW-1] ^ det0[PW-1];
      c_det0z <= (det0 == '0);
      c_detqz <= (detq == '0);
      c_flip  <= (det0 == '0) || (detq == '0) || (detq[PW-1] != det0[PW-1]);
    end
  end

  // Map entries: four dividers by the rest determinant.
  logic               v1;
  logic [J_QBITS-1:0] qa, qb, qc, qd;
  logic               oa, ob, oc, od;
  logic [3:0]         pa1;
  logic               pb1, pc1, pd1;

  tmde_div #(.NW(XW1), .DW(PW), .QW(J_QBITS), .PLW(4)) u_div_a (
    .clk(clk), .rst(rst), .en(adv), .vld_in(vc), .x(xa), .d(dj),
    .pay_in({c_flip, c_det0z, c_detqz, sa}),
    .vld_out(v1), .q(qa), .ovf(oa), .pay_out(pa1)
  );
  tmde_div #(.NW(XW1), .DW(PW), .QW(J_QBITS), .PLW(1)) u_div_b (
    .clk(clk), .rst(rst), .en(adv), .vld_in(vc), .x(xb), .d(dj), .pay_in(sb),
    .vld_out(), .q(qb), .ovf(ob), .pay_out(pb1)
  );
  tmde_div #(.NW(XW1), .DW(PW), .QW(J_QBITS), .PLW(1)) u_div_c (
    .clk(clk), .rst(rst), .en(adv), .vld_in(vc), .x(xc_j), .d(dj), .pay_in(sc),
    .vld_out(), .q(qc), .ovf(oc), .pay_out(pc1)
  );
  tmde_div #(.NW(XW1), .DW(PW), .QW(J_QBITS), .PLW(1)) u_div_d (
    .clk(clk), .rst(rst), .en(adv), .vld_in(vc), .x(xd), .d(dj), .pay_in(sd),
    .vld_out(), .q(qd), .ovf(od), .pay_out(pd1)
  );

  // Stage D: clamp and sign the entries.
  logic               vd;
  logic signed [30:0] ja, jb, jc, jd;
  logic [30:0]        ma, mb, mc, md;
  logic [2:0]         d_flags;

  assign ma = {1'b0, oa ? {J_QBITS{1'b1}} : qa};
  assign mb = {1'b0, ob ? {J_QBITS{1'b1}} : qb};
  assign mc = {1'b0, oc ? {J_QBITS{1'b1}} : qc};
  assign md = {1'b0, od ? {J_QBITS{1'b1}} : qd};

  always_ff @(posedge clk) begin
    if (adv) begin
      ja      <= pa1[0] ? (31'd0 - ma) : ma;
      jb      <= pb1 ? (31'd0 - mb) : mb;
      jc      <= pc1 ? (31'd0 - mc) : mc;
      jd      <= pd1 ? (31'd0 - md) : md;
      d_flags <= pa1[3:1];
    end
  end

  // Stage E: sums and differences of the entries.
  logic               ve;
  logic signed [31:0] eu, ew, ey, ez;
  logic signed [30:0] ea, eb, ec, ed_j;
  logic [2:0]         e_flags;

  always_ff @(posedge clk) begin
    if (adv) begin
      eu      <= 32'(ja) + 32'(jd);
      ew      <= 32'(jc) - 32'(jb);
      ey      <= 32'(ja) - 32'(jd);
      ez      <= 32'(jc) + 32'(jb);
      ea      <= ja;
      eb      <= jb;
      ec      <= jc;
      ed_j    <= jd;
      e_flags <= d_flags;
    end
  end

  // Stage F: squares and the determinant products.
  logic               vf;
  logic signed [63:0] uu, ww, yy, zz, ad, bc;
  logic [2:0]         f_flags;

  always_ff @(posedge clk) begin
    if (adv) begin
      uu      <= eu * eu;
      ww      <= ew * ew;
      yy      <= ey * ey;
      zz      <= ez * ez;
      ad      <= ea * ed_j;
      bc      <= eb * ec;
      f_flags <= e_flags;
    end
  end

  // Stage G: radicands and det J.
  logic               vg;
  logic [63:0]        rada, radb;
  logic signed [63:0] detj;
  logic [2:0]         g_flags;

  always_ff @(posedge clk) begin
    if (adv) begin
      rada    <= uu + ww;
      radb    <= yy + zz;
      detj    <= ad - bc;
      g_flags <= f_flags;
    end
  end

  // Two square roots.
  logic        v2;
  logic [31:0] ra, rb;
  logic [63:0] detj2;
  logic [2:0]  flags2;

  tmde_isqrt #(.XW(64), .PLW(64)) u_sqrt_a (
    .clk(clk), .rst(rst), .en(adv), .vld_in(vg), .x(rada), .pay_in(detj),
    .vld_out(v2), .root(ra), .pay_out(detj2)
  );
  tmde_isqrt #(.XW(64), .PLW(3)) u_sqrt_b (
    .clk(clk), .rst(rst), .en(adv), .vld_in(vg), .x(radb), .pay_in(g_flags),
    .vld_out(), .root(rb), .pay_out(flags2)
  );

  // Stage H: major singular value and |det J|.
  logic        vh;
  logic [32:0] rsum;
  logic [31:0] h_s1;
  logic [63:0] magj;
  logic [2:0]  h_flags;

  assign rsum = {1'b0, ra} + {1'b0, rb};

  always_ff @(posedge clk) begin
    if (adv) begin
      h_s1    <= rsum[32:1];
      magj    <= detj2[63] ? (~detj2 + 1'b1) : detj2;
      h_flags <= flags2;
    end
  end

  // Stage I: rounded dividend for the minor value.
  logic        vi;
  logic [63:0] xmin;
  logic [31:0] i_s1;
  logic [2:0]  i_flags;

  always_ff @(posedge clk) begin
    if (adv) begin
      xmin    <= magj + 64'(h_s1 >> 1);
      i_s1    <= h_s1;
      i_flags <= h_flags;
    end
  end

  // Minor value divider.
  logic        v3;
  logic [31:0] qmin;
  logic        omin;
  logic [34:0] pay3;

  tmde_div #(.NW(64), .DW(32), .QW(32), .PLW(35)) u_div_min (
    .clk(clk), .rst(rst), .en(adv), .vld_in(vi), .x(xmin), .d(i_s1),
    .pay_in({i_s1, i_flags}),
    .vld_out(v3), .q(qmin), .ovf(omin), .pay_out(pay3)
  );

  // Stage J: limit the minor value and settle the degenerate flag.
  logic        vj;
  logic [31:0] s1_3, s2raw, s2lim;
  logic        flip3, det0z3, detqz3;
  logic [31:0] j_s1, j_s2;
  logic        j_degen, j_flip, j_det0z;

  assign {s1_3, flip3, det0z3, detqz3} = pay3;
  assign s2raw = omin ? s1_3 : qmin;
  assign s2lim = (s2raw > s1_3) ? s1_3 : s2raw;

  always_ff @(posedge clk) begin
    if (adv) begin
      j_s1    <= s1_3;
      j_s2    <= detqz3 ? 32'd0 : s2lim;
      j_degen <= det0z3 || detqz3 || (s2lim == 32'd0);
      j_flip  <= flip3;
      j_det0z <= det0z3;
    end
  end

  // Stage K: squares of the singular values.
  logic        vk;
  logic [47:0] k_p1, k_p2;
  logic [49:0] k_ss1, k_ss2;
  logic        k_big1, k_big2, k_small1, k_small2, k_zero1, k_zero2;
  logic [31:0] k_s1, k_s2;
  logic        k_degen, k_flip, k_det0z;

  always_ff @(posedge clk) begin
    if (adv) begin
      k_p1     <= j_s1[23:0] * j_s1[23:0];
      k_p2     <= j_s2[23:0] * j_s2[23:0];
      k_ss1    <= j_s1[24:0] * j_s1[24:0];
      k_ss2    <= j_s2[24:0] * j_s2[24:0];
      k_big1   <= |j_s1[31:24];
      k_big2   <= |j_s2[31:24];
      k_small1 <= (j_s1 < 32'd256);
      k_small2 <= (j_s2 < 32'd256);
      k_zero1  <= |j_s1[31:25];
      k_zero2  <= |j_s2[31:25];
      k_s1     <= j_s1;
      k_s2     <= j_s2;
      k_degen  <= j_degen;
      k_flip   <= j_flip;
      k_det0z  <= j_det0z;
    end
  end

  // Stage L: rounded squares and the dividends of the inverse and ratio terms.
  logic        vl;
  energy_t     l_a1, l_a2;
  logic [49:0] l_xi1, l_xi2, l_di1, l_di2;
  logic [48:0] l_xm1, l_xm2;
  logic [31:0] l_s1, l_s2;
  logic [1:0]  l_f1, l_f2;
  logic        l_degen, l_flip, l_det0z;

  always_ff @(posedge clk) begin
    if (adv) begin
      l_a1    <= k_big1 ? ENERGY_BIG : 34'((k_p1 + 48'h8000) >> 16);
      l_a2    <= k_big2 ? ENERGY_BIG : 34'((k_p2 + 48'h8000) >> 16);
      l_xi1   <= (50'd1 << 48) + (k_ss1 >> 1);
      l_xi2   <= (50'd1 << 48) + (k_ss2 >> 1);
      l_di1   <= k_ss1;
      l_di2   <= k_ss2;
      l_xm1   <= {1'b0, k_s1, 16'd0} + 49'(k_s2 >> 1);
      l_xm2   <= {1'b0, k_s2, 16'd0} + 49'(k_s1 >> 1);
      l_s1    <= k_s1;
      l_s2    <= k_s2;
      l_f1    <= {k_zero1, k_small1};
      l_f2    <= {k_zero2, k_small2};
      l_degen <= k_degen;
      l_flip  <= k_flip;
      l_det0z <= k_det0z;
    end
  end

  // Inverse squares and ratio terms: four dividers.
  logic        v4;
  logic [32:0] qi1, qi2, qm1, qm2;
  logic        oi1, oi2, om1, om2;
  logic [1:0]  f1_4, f2_4;
  logic [134:0] pay4;
  logic        degen4b;

  tmde_div #(.NW(50), .DW(50), .QW(33), .PLW(2)) u_div_inv1 (
    .clk(clk), .rst(rst), .en(adv), .vld_in(vl), .x(l_xi1), .d(l_di1), .pay_in(l_f1),
    .vld_out(), .q(qi1), .ovf(oi1), .pay_out(f1_4)
  );
  tmde_div #(.NW(50), .DW(50), .QW(33), .PLW(2)) u_div_inv2 (
    .clk(clk), .rst(rst), .en(adv), .vld_in(vl), .x(l_xi2), .d(l_di2), .pay_in(l_f2),
    .vld_out(), .q(qi2), .ovf(oi2), .pay_out(f2_4)
  );
  tmde_div #(.NW(49), .DW(32), .QW(33), .PLW(135)) u_div_mips1 (
    .clk(clk), .rst(rst), .en(adv), .vld_in(vl), .x(l_xm1), .d(l_s2),
    .pay_in({l_a1, l_a2, l_s1, l_s2, l_flip, l_det0z, l_degen}),
    .vld_out(v4), .q(qm1), .ovf(om1), .pay_out(pay4)
  );
  tmde_div #(.NW(49), .DW(32), .QW(33), .PLW(1)) u_div_mips2 (
    .clk(clk), .rst(rst), .en(adv), .vld_in(vl), .x(l_xm2), .d(l_s1), .pay_in(l_degen),
    .vld_out(), .q(qm2), .ovf(om2), .pay_out(degen4b)
  );

  // Stage M: energy sums with saturation.
  logic        vm;
  energy_t     a1_4, a2_4, i1, i2, m1, m2;
  logic [31:0] s1_4, s2_4;
  logic        flip4, det0z4, degen4;
  logic [35:0] sum_d, sum_s, sum_m;
  logic [31:0] m_ed, m_es, m_em, m_s1, m_s2;
  logic        m_flip, m_det0z, m_degen;

  assign {a1_4, a2_4, s1_4, s2_4, flip4, det0z4, degen4} = pay4;
  assign i1 = f1_4[0] ? ENERGY_BIG : (f1_4[1] ? '0 : (oi1 ? ENERGY_BIG : {1'b0, qi1}));
  assign i2 = f2_4[0] ? ENERGY_BIG : (f2_4[1] ? '0 : (oi2 ? ENERGY_BIG : {1'b0, qi2}));
  assign m1 = om1 ? ENERGY_BIG : {1'b0, qm1};
  assign m2 = om2 ? ENERGY_BIG : {1'b0, qm2};
  assign sum_d = 36'(a1_4) + 36'(a2_4);
  assign sum_s = 36'(a1_4) + 36'(a2_4) + 36'(i1) + 36'(i2);
  assign sum_m = 36'(m1) + 36'(m2);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ed    <= (degen4 || |sum_d[35:32]) ? 32'hFFFF_FFFF : sum_d[31:0];
      m_es    <= (degen4 || |sum_s[35:32]) ? 32'hFFFF_FFFF : sum_s[31:0];
      m_em    <= (degen4b || |sum_m[35:32]) ? 32'hFFFF_FFFF : sum_m[31:0];
      m_s1    <= s1_4;
      m_s2    <= s2_4;
      m_flip  <= flip4;
      m_det0z <= det0z4;
      m_degen <= degen4;
    end
  end

  // Stage N: select the colour energy and saturate the singular values.
  logic        vn;
  logic [31:0] esel, ebase;
  logic [31:0] n_diff, n_ed, n_es, n_em;
  logic [23:0] n_major, n_minor;
  logic        n_flip, n_degen;

  always_comb begin
    case (energy_mode)
      MODE_DIRICHLET: esel = m_ed;
      MODE_SYMMETRIC: esel = m_es;
      default:        esel = m_em;
    endcase
    ebase = (energy_mode == MODE_SYMMETRIC) ? BASE_HIGH : BASE_LOW;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_diff  <= (esel > ebase) ? (esel - ebase) : 32'd0;
      n_major <= (m_det0z || |m_s1[31:24]) ? 24'hFF_FFFF : m_s1[23:0];
      n_minor <= m_det0z ? 24'd0 : (|m_s2[31:24] ? 24'hFF_FFFF : m_s2[23:0]);
      n_ed    <= m_ed;
      n_es    <= m_es;
      n_em    <= m_em;
      n_flip  <= m_flip;
      n_degen <= m_degen;
    end
  end

  // Stage O: scaled colour dividend.
  logic         vo;
  logic [40:0]  o_xc;
  logic [145:0] o_pay;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_xc  <= 41'(n_diff) * 41'd255 + COLOUR_HALF;
      o_pay <= {n_major, n_minor, n_ed, n_es, n_em, n_flip, n_degen};
    end
  end

  // Stage P: colour level. The dividend over 2^17 is divided by ten through a
  // reciprocal multiply; at or above the clamp point the level is full scale.
  logic         v5;
  logic [11:0]  lvl_y;
  logic [24:0]  lvl_prod;
  logic [7:0]   qlvl;
  logic         olvl;
  logic [145:0] pay5;
  logic [23:0]  major5, minor5;
  logic [31:0]  ed5, es5, em5;
  logic         flip5, degen5;

  assign lvl_y    = o_xc[28:17];
  assign lvl_prod = 25'(lvl_y) * 25'(COLOUR_RECIP);

  always_ff @(posedge clk) begin
    if (adv) begin
      qlvl <= lvl_prod[23:16];
      olvl <= (o_xc[40:17] >= COLOUR_CLAMP);
      pay5 <= o_pay;
    end
  end

  assign {major5, minor5, ed5, es5, em5, flip5, degen5} = pay5;

  // Valid bits of the local stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; ve <= 1'b0; vf <= 1'b0;
      vg <= 1'b0; vh <= 1'b0; vi <= 1'b0; vj <= 1'b0; vk <= 1'b0; vl <= 1'b0;
      vm <= 1'b0; vn <= 1'b0; vo <= 1'b0; v5 <= 1'b0; m_tvalid <= 1'b0;
    end else if (adv) begin
      va <= s_tvalid; vb <= va; vc <= vb;
      vd <= v1; ve <= vd; vf <= ve; vg <= vf;
      vh <= v2; vi <= vh;
      vj <= v3; vk <= vj; vl <= vk;
      vm <= v4; vn <= vm; vo <= vn; v5 <= vo;
      m_tvalid <= v5;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {(energy_mode == MODE_NONE) ? 8'd0 : (olvl ? 8'hFF : qlvl),
                  em5, es5, ed5, minor5, major5};
      m_tuser <= {degen5, flip5};
    end
  end

  // Checks.
  a_degen_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[79:48] == 32'hFFFF_FFFF
                               && m_tdata[143:112] == 32'hFFFF_FFFF)
    else $error("degenerate item without saturated energies");

  a_sigma_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[47:24] <= m_tdata[23:0])
    else $error("minor singular value above major");

  a_mode_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && energy_mode == MODE_NONE |-> m_tdata[151:144] == 8'd0)
    else $error("colour level set with unused mode");

endmodule

>>> sv/tmde_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
// Flags when the quotient does not fit in QW bits. Uses no package.
module tmde_div #(
  parameter int NW  = 8,
  parameter int DW  = 8,
  parameter int QW  = 8,
  parameter int PLW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           vld_in,
  input  logic [NW-1:0]  x,
  input  logic [DW-1:0]  d,
  input  logic [PLW-1:0] pay_in,
  output logic           vld_out,
  output logic [QW-1:0]  q,
  output logic           ovf,
  output logic [PLW-1:0] pay_out
);
  localparam int RW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [QW:0]    vld;
  logic [RW-1:0]  rem [QW+1];
  logic [DW-1:0]  dv  [QW+1];
  logic [QW-1:0]  qt  [QW+1];
  logic           ov  [QW+1];
  logic [PLW-1:0] pl  [QW+1];

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QW-1:0], vld_in};
    end
  end

  // First stage: load the dividend and check for a quotient that is too wide.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= RW'(x);
      dv[0]  <= d;
      qt[0]  <= '0;
      ov[0]  <= (RW'(x) >= (RW'(d) << QW));
      pl[0]  <= pay_in;
    end
  end

  // One compare and subtract per stage, most significant bit first.
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [RW-1:0] trial;
    logic          take;
    assign trial = RW'(dv[k-1]) << (QW - k);
    assign take  = rem[k-1] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? (rem[k-1] - trial) : rem[k-1];
        qt[k]  <= qt[k-1] | (take ? (QW'(1) << (QW - k)) : QW'(0));
        dv[k]  <= dv[k-1];
        ov[k]  <= ov[k-1];
        pl[k]  <= pl[k-1];
      end
    end
  end

  assign vld_out = vld[QW];
  assign q       = qt[QW];
  assign ovf     = ov[QW];
  assign pay_out = pl[QW];

endmodule

>>> sv/tmde_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a side payload.
// Uses no package.
module tmde_isqrt #(
  parameter int XW  = 64,
  parameter int PLW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            vld_in,
  input  logic [XW-1:0]   x,
  input  logic [PLW-1:0]  pay_in,
  output logic            vld_out,
  output logic [XW/2-1:0] root,
  output logic [PLW-1:0]  pay_out
);
  localparam int RW = XW / 2;

  logic [RW:0]    vld;
  logic [XW:0]    rem [RW+1];
  logic [XW:0]    acc [RW+1];
  logic [PLW-1:0] pl  [RW+1];

  // Valid bits move with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[RW-1:0], vld_in};
    end
  end

  // First stage: load the radicand.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (XW+1)'(x);
      acc[0] <= '0;
      pl[0]  <= pay_in;
    end
  end

  // Digit-by-digit root, one bit pair of the radicand per stage.
  for (genvar k = 1; k <= RW; k++) begin : g_stage
    logic [XW:0] bt;
    logic [XW:0] trial;
    logic        take;
    assign bt    = (XW+1)'(1) << (XW - 2 * k);
    assign trial = acc[k-1] + bt;
    assign take  = rem[k-1] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? (rem[k-1] - trial) : rem[k-1];
        acc[k] <= take ? ((acc[k-1] >> 1) + bt) : (acc[k-1] >> 1);
        pl[k]  <= pl[k-1];
      end
    end
  end

  assign vld_out = vld[RW];
  assign root    = acc[RW][RW-1:0];
  assign pay_out = pl[RW];

endmodule
